FILE: design/edfe_pkg.sv
`default_nettype none
package edfe_pkg;

  localparam logic [4:0] VecDe = 5'd0;
  localparam logic [4:0] VecDf = 5'd8;
  localparam logic [4:0] VecAc = 5'd17;
  localparam int unsigned NumVectors = 20;

  typedef enum logic {
    CmdRaise = 1'b0,
    CmdDone  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StDeliver = 2'd0,
    StTriple  = 2'd1,
    StUnknown = 2'd2,
    StCleared = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ClsBenign  = 2'd0,
    ClsContrib = 2'd1,
    ClsPage    = 2'd2,
    ClsDouble  = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    KindUnknown    = 3'd0,
    KindRestart    = 3'd1,
    KindTrap       = 3'd2,
    KindDouble     = 3'd3,
    KindRestartErr = 3'd4,
    KindAlign      = 3'd5
  } kind_e;

  typedef struct packed {
    cmd_e        command;
    logic [4:0]  vector;
    logic [31:0] fault_code;
    logic        stack_backout;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  deliver_vector;
    logic        push_error;
    logic [31:0] fault_code_out;
    logic        restore_ip;
    logic        restore_sp;
  } out_item_t;

  typedef struct packed {
    logic [1:0] nest_count;
    logic [4:0] last_vector;
  } state_t;

  function automatic class_e vec_class(input logic [4:0] vec);
    class_e cls;
    case (vec)
      5'd0, 5'd10, 5'd11, 5'd12, 5'd13: cls = ClsContrib;
      5'd8:                             cls = ClsDouble;
      5'd14:                            cls = ClsPage;
      default:                          cls = ClsBenign;
    endcase
    return cls;
  endfunction

  function automatic kind_e vec_kind(input logic [4:0] vec);
    kind_e kind;
    case (vec)
      5'd0, 5'd1, 5'd5, 5'd6, 5'd7, 5'd16:  kind = KindRestart;
      5'd2, 5'd3, 5'd4:                     kind = KindTrap;
      5'd8:                                 kind = KindDouble;
      5'd10, 5'd11, 5'd12, 5'd13, 5'd14:    kind = KindRestartErr;
      5'd17:                                kind = KindAlign;
      default:                              kind = KindUnknown;
    endcase
    return kind;
  endfunction

  // escalation table indexed by previous class and new class
  function automatic logic escalates(input class_e prev, input class_e cur);
    logic esc;
    case (prev)
      ClsBenign:  esc = (cur == ClsDouble);
      ClsContrib: esc = (cur == ClsContrib) || (cur == ClsDouble);
      ClsPage:    esc = (cur != ClsBenign);
      default:    esc = 1'b1;
    endcase
    return esc;
  endfunction

endpackage
`default_nettype wire

FILE: design/edfe_eval.sv
`default_nettype none
module edfe_eval
  import edfe_pkg::*;
(
  input  wire in_item_t item_i,
  input  wire state_t   state_i,
  output out_item_t     result_o,
  output state_t        state_o
);

  localparam logic [5:0] NumVec = 6'(NumVectors);

  logic [1:0]  nest_inc;
  logic        triple;
  logic        esc;
  kind_e       kind;
  out_item_t   res;

  always_comb begin
    nest_inc = (state_i.nest_count == 2'd3) ? 2'd3 : state_i.nest_count + 2'd1;
    triple   = (nest_inc == 2'd3) ||
               ((nest_inc == 2'd2) && (state_i.last_vector == VecDf));
    kind     = ({1'b0, item_i.vector} < NumVec) ? vec_kind(item_i.vector) : KindUnknown;
    esc      = (nest_inc[1]) &&
               escalates(vec_class(state_i.last_vector), vec_class(item_i.vector));

    res         = '0;
    res.status  = StDeliver;
    state_o     = state_i;

    if (item_i.command == CmdDone) begin
      res.status         = StCleared;
      state_o.nest_count = 2'd0;
    end else if (triple) begin
      res.status         = StTriple;
      state_o.nest_count = nest_inc;
    end else begin
      state_o.nest_count = nest_inc;
      res.deliver_vector = item_i.vector;
      res.fault_code_out = item_i.fault_code;
      case (kind)
        KindRestart: begin
          res.restore_ip = 1'b1;
          res.restore_sp = item_i.stack_backout;
        end
        KindTrap: begin
        end
        KindDouble: begin
          res.push_error     = 1'b1;
          res.fault_code_out = '0;
        end
        KindRestartErr: begin
          res.restore_ip = 1'b1;
          res.restore_sp = item_i.stack_backout;
          res.push_error = 1'b1;
        end
        KindAlign: begin
          res.restore_ip     = 1'b1;
          res.restore_sp     = item_i.stack_backout;
          res.push_error     = 1'b1;
          res.fault_code_out = '0;
        end
        default: begin
          res = '0;
          res.status = StUnknown;
        end
      endcase
      if (res.status == StDeliver) begin
        // a second nested fault whose class pair escalates is promoted to a double fault
        if (esc) begin
          res.deliver_vector = VecDf;
          res.push_error     = 1'b1;
          res.fault_code_out = '0;
        end
        state_o.last_vector = res.deliver_vector;
      end
    end
    result_o = res;
  end

endmodule
`default_nettype wire

FILE: design/exception_double_fault_escalation.sv
// Exception escalation unit: each transfer in is a raise or a delivery-done
// command and yields exactly one result, which passes through the input
// register, then the result register. One item per cycle is sustained while
// the output is not stalled; the nesting count and last-vector registers are
// updated in the same cycle an item moves from the input register into the
// result register, so the next item sees them at once. A held result stalls
// the input side only when both registers are full.
`default_nettype none
module exception_double_fault_escalation
  import edfe_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  output out_item_t     out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      res_valid_q;
  out_item_t res_q;
  out_item_t res_d;
  state_t    state_q;
  state_t    state_d;
  logic      res_free;
  logic      advance;

  assign res_free   = !res_valid_q || !out_stall_i;
  assign advance    = in_valid_q && res_free;
  assign in_stall_o = in_valid_q && !res_free;

  edfe_eval u_eval (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .result_o (res_d),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (res_free) begin
        res_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_item_q.command == CmdDone) |=> (state_q.nest_count == 2'd0))
    else $error("nest count not cleared after delivery done");

  a_triple_nested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.status == StTriple) |-> state_q.nest_count[1])
    else $error("triple fault without nested faults");

  a_df_pushes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.status == StDeliver) && (res_q.deliver_vector == VecDf)
      |-> res_q.push_error && (res_q.fault_code_out == '0))
    else $error("double fault delivered without zero error code");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> !in_stall_o)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none
module testbench;
  import edfe_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  exception_double_fault_escalation u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  in_item_t   command_q[$];
  out_item_t  outcome_q[$];
  int         mismatches = 0;

  // shadow of the nesting count and the last delivered vector
  logic [1:0] nest_cnt;
  logic [4:0] last_vec;

  initial forever #1 clk = ~clk;

  function automatic class_e class_of(input logic [4:0] vec);
    case (vec)
      5'd0, 5'd10, 5'd11, 5'd12, 5'd13: return ClsContrib;
      5'd14:                            return ClsPage;
      5'd8:                             return ClsDouble;
      default:                          return ClsBenign;
    endcase
  endfunction

  // work out the result of one accepted transfer and move the shadow state on
  function automatic void escalation_outcome(input in_item_t it);
    // row per previous class, one bit per new class
    logic [3:0] df_rows [4] = '{4'b1000, 4'b1010, 4'b1110, 4'b1111};
    out_item_t  res;
    kind_e      kind;
    logic [4:0] vec;
    logic [31:0] code;
    res = '0;
    vec = it.vector;
    code = it.fault_code;
    if (it.command == CmdDone) begin
      nest_cnt = 2'd0;
      res.status = StCleared;
      outcome_q.push_back(res);
      return;
    end
    if (nest_cnt != 2'd3) nest_cnt = nest_cnt + 2'd1;
    if (nest_cnt == 2'd3 || (nest_cnt == 2'd2 && last_vec == VecDf)) begin
      res.status = StTriple;
      outcome_q.push_back(res);
      return;
    end
    case (vec)
      5'd0, 5'd1, 5'd5, 5'd6, 5'd7, 5'd16: kind = KindRestart;
      5'd2, 5'd3, 5'd4:                    kind = KindTrap;
      5'd8:                                kind = KindDouble;
      5'd10, 5'd11, 5'd12, 5'd13, 5'd14:   kind = KindRestartErr;
      5'd17:                               kind = KindAlign;
      default:                             kind = KindUnknown;
    endcase
    if (kind == KindUnknown) begin
      res.status = StUnknown;
      outcome_q.push_back(res);
      return;
    end
    res.status = StDeliver;
    res.restore_ip = (kind == KindRestart || kind == KindRestartErr || kind == KindAlign);
    res.restore_sp = res.restore_ip & it.stack_backout;
    res.push_error = (kind == KindDouble || kind == KindRestartErr || kind == KindAlign);
    if (kind == KindDouble || kind == KindAlign) code = '0;
    if (nest_cnt >= 2'd2 && df_rows[class_of(last_vec)][class_of(vec)]) begin
      vec = VecDf;
      res.push_error = 1'b1;
      code = '0;
    end
    last_vec = vec;
    res.deliver_vector = vec;
    // the code goes out even when nothing is pushed
    res.fault_code_out = code;
    outcome_q.push_back(res);
  endfunction

  task automatic add_cmd(input cmd_e c, input logic [4:0] v, input logic [31:0] code,
                         input logic bo);
    in_item_t it;
    it.command = c;
    it.vector = v;
    it.fault_code = code;
    it.stack_backout = bo;
    command_q.push_back(it);
  endtask

  function automatic logic [31:0] rand_code();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] rand_vec();
    if ($urandom_range(0, 4) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 19));
  endfunction

  // sending side
  logic [2:0] in_idle = '0;
  logic       in_burst = 1'b0;
  always @(posedge clk or negedge rst_n) begin
    logic       nxt_valid;
    logic [2:0] nxt_idle;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_idle <= '0;
      nest_cnt = 2'd0;
      last_vec = 5'd0;
    end else begin
      nxt_valid = in_valid;
      nxt_idle = in_idle;
      if (in_valid && !in_stall) begin
        escalation_outcome(in_item);
        nxt_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) in_burst <= ~in_burst;
        nxt_idle = in_burst ? 3'd0 : 3'($urandom_range(0, 4));
      end
      if (!nxt_valid) begin
        if (nxt_idle != 3'd0) nxt_idle = nxt_idle - 3'd1;
        else if (command_q.size() != 0) begin
          in_item <= command_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
      in_idle <= nxt_idle;
    end
  end

  // receiving side
  logic [2:0] out_hold = '0;
  logic       out_burst = 1'b0;
  always @(posedge clk or negedge rst_n) begin
    logic [2:0] nxt_hold;
    out_item_t  want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold <= '0;
    end else begin
      nxt_hold = out_hold;
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with nothing outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (out_item.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_item.status);
            mismatches++;
          end
          if (out_item.deliver_vector !== want.deliver_vector) begin
            $error("deliver_vector exp %0d got %0d", want.deliver_vector,
                   out_item.deliver_vector);
            mismatches++;
          end
          if (out_item.push_error !== want.push_error) begin
            $error("push_error exp %0b got %0b", want.push_error, out_item.push_error);
            mismatches++;
          end
          if (out_item.fault_code_out !== want.fault_code_out) begin
            $error("fault_code_out exp %08h got %08h", want.fault_code_out,
                   out_item.fault_code_out);
            mismatches++;
          end
          if (out_item.restore_ip !== want.restore_ip) begin
            $error("restore_ip exp %0b got %0b", want.restore_ip, out_item.restore_ip);
            mismatches++;
          end
          if (out_item.restore_sp !== want.restore_sp) begin
            $error("restore_sp exp %0b got %0b", want.restore_sp, out_item.restore_sp);
            mismatches++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_burst <= ~out_burst;
        nxt_hold = out_burst ? 3'd0 : 3'($urandom_range(0, 4));
      end else if (nxt_hold != 3'd0) begin
        nxt_hold = nxt_hold - 3'd1;
      end
      out_stall <= (nxt_hold != 3'd0);
      out_hold <= nxt_hold;
    end
  end

  initial begin
    int n_items;
    int depth;
    // directed: count clearing, saturation, both triple fault paths,
    // escalation pairs, error code forcing and unknown vectors
    add_cmd(CmdRaise, 5'd0, 32'd0, 1'b0);
    add_cmd(CmdDone, 5'd31, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CmdRaise, 5'd14, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CmdRaise, 5'd14, 32'h1234_5678, 1'b1);
    add_cmd(CmdRaise, 5'd1, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CmdRaise, 5'd3, 32'd0, 1'b0);
    add_cmd(CmdDone, 5'd0, 32'd0, 1'b0);
    add_cmd(CmdRaise, VecDf, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CmdRaise, 5'd2, 32'd7, 1'b0);
    add_cmd(CmdDone, 5'd0, 32'd0, 1'b0);
    add_cmd(CmdRaise, VecAc, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CmdRaise, 5'd10, 32'hA5A5_5A5A, 1'b1);
    add_cmd(CmdDone, 5'd0, 32'd0, 1'b0);
    add_cmd(CmdRaise, 5'd9, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CmdRaise, 5'd15, 32'd1, 1'b1);
    add_cmd(CmdDone, 5'd0, 32'd0, 1'b0);
    add_cmd(CmdRaise, 5'd31, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CmdDone, 5'd0, 32'd0, 1'b0);
    add_cmd(CmdRaise, 5'd13, 32'h0000_00FF, 1'b0);
    add_cmd(CmdRaise, VecDe, 32'hFFFF_0000, 1'b1);
    add_cmd(CmdDone, 5'd0, 32'd0, 1'b0);
    add_cmd(CmdRaise, 5'd16, 32'h8000_0001, 1'b1);
    add_cmd(CmdRaise, 5'd4, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CmdDone, 5'd0, 32'd0, 1'b0);
    add_cmd(CmdRaise, 5'd20, 32'd3, 1'b0);

    // random: mostly clear-then-nest sequences, some stray single commands
    n_items = command_q.size();
    while (n_items < 1500) begin
      if ($urandom_range(0, 6) != 0) begin
        add_cmd(CmdDone, 5'($urandom_range(0, 31)), $urandom, 1'($urandom));
        depth = ($urandom_range(0, 7) == 0) ? 4 : $urandom_range(1, 3);
        repeat (depth) add_cmd(CmdRaise, rand_vec(), rand_code(), 1'($urandom));
        n_items += depth + 1;
      end else begin
        add_cmd($urandom_range(0, 1) ? CmdDone : CmdRaise, rand_vec(), rand_code(),
                1'($urandom));
        n_items++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (command_q.size() != 0 || in_valid) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0)
      $display("PASS exception_double_fault_escalation");
    else
      $display("FAIL exception_double_fault_escalation");
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL exception_double_fault_escalation");
    $finish;
  end

endmodule
`default_nettype wire
